// File: hdl/bst_pkg.sv
// bank slot translator package: codes, widths and memory size lookup
// used by bst_rem and bank_slot_translator
`default_nettype none
package bst_pkg;

  localparam int unsigned SIZE_W    = 23;
  localparam int unsigned DIVD_W    = 33;
  localparam int unsigned PRG_PAGE_LOG2 = 12;
  localparam int unsigned CHR_PAGE_LOG2 = 10;
  localparam int unsigned EXRAM_BYTES = 1024;
  localparam int unsigned CIRAM_BYTES = 16384;

  localparam logic [2:0] CMD_XLATE  = 3'd0;
  localparam logic [2:0] CMD_MAP    = 3'd1;
  localparam logic [2:0] CMD_UNMAP  = 3'd2;
  localparam logic [2:0] CMD_NT     = 3'd3;
  localparam logic [2:0] CMD_MIRROR = 3'd4;

  localparam logic [1:0] MEM_ROM   = 2'd0;
  localparam logic [1:0] MEM_RAM   = 2'd1;
  localparam logic [1:0] MEM_XRAM  = 2'd2;
  localparam logic [1:0] MEM_NTRAM = 2'd3;

  localparam logic [3:0] TYPE_CHR_CIRAM = 4'd7;

  localparam logic [1:0] REG_PRG_ROM = 2'd0;
  localparam logic [1:0] REG_PRG_RAM = 2'd1;
  localparam logic [1:0] REG_CHR_ROM = 2'd2;
  localparam logic [1:0] REG_CHR_RAM = 2'd3;

  // first field in the highest bits, last field (cmd) in the lowest
  typedef struct packed {
    logic [31:0] mirror_word;
    logic [21:0] nt_offset;
    logic [2:0]  nt_dest;
    logic [5:0]  bank_kb;
    logic [15:0] bank;
    logic [7:0]  write_value;
    logic        is_write;
    logic [15:0] addr;
    logic [3:0]  mem_type;
    logic [2:0]  cmd;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  write_data;
    logic        write_enable;
    logic [22:0] phys_offset;
    logic [1:0]  mem_select;
    logic        region;
    logic        hit;
  } out_item_t;

  function automatic logic [SIZE_W-1:0] mem_size(
    input logic              region,
    input logic [1:0]        sel,
    input logic [SIZE_W-1:0] prg_rom,
    input logic [SIZE_W-1:0] prg_ram,
    input logic [SIZE_W-1:0] chr_rom,
    input logic [SIZE_W-1:0] chr_ram
  );
    logic [SIZE_W-1:0] s;
    if (!region) begin
      unique case (sel)
        MEM_ROM: s = prg_rom;
        MEM_RAM: s = prg_ram;
        default: s = '0;
      endcase
    end else begin
      unique case (sel)
        MEM_ROM:   s = chr_rom;
        MEM_RAM:   s = chr_ram;
        MEM_XRAM:  s = SIZE_W'(EXRAM_BYTES);
        MEM_NTRAM: s = SIZE_W'(CIRAM_BYTES);
      endcase
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// File: hdl/bank_slot_translator.sv
// bank slot translator top level: slot table memory, command sequencer
// depends on bst_pkg and bst_rem
//
// channel  dir  width  contents
// s_axis   in   112    cmd, mem_type, addr, is_write, write_value, bank,
//                      bank_kb, nt_dest, nt_offset, mirror_word
// m_axis   out  40     hit, region, mem_select, phys_offset, write_enable,
//                      write_data
// cfg      in   23     size registers, index 0 to 3
//
// one transaction at a time; translate reads the table, then registers the result
// map bank forms the bank offset, then fills each slot from the serial remainder unit
// map nametable writes one or two slots, map mirroring writes eight slots
// rst clears the size registers and every slot valid bit at once
// a stalled result is held; the next transaction is taken as it leaves
`default_nettype none
module bank_slot_translator #(
  parameter int unsigned OFFSET_BITS = 22
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  // cmd, mem_type, addr, is_write, write_value, bank, bank_kb, nt_dest,
  // nt_offset, mirror_word, zero pad
  input  wire logic [111:0]  s_tdata,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  // hit, region, mem_select, phys_offset, write_enable, write_data, zero pad
  output logic [39:0]        m_tdata,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [22:0]   cfg_data
);

  localparam int unsigned EW   = 4 + OFFSET_BITS;
  localparam int unsigned SUMW = (OFFSET_BITS > 23) ? OFFSET_BITS : 23;

  typedef enum logic [3:0] {
    S_IDLE, S_XLATE, S_MUL, S_LOOP, S_DIV, S_WR, S_NT1, S_NT2, S_MIR, S_FIN
  } state_t;

  state_t state;

  bst_pkg::in_item_t  in_item;
  bst_pkg::out_item_t out_q;
  bst_pkg::out_item_t xl;

  logic [22:0] prg_rom, prg_ram, chr_rom, chr_ram;

  logic [EW-1:0] mem [64];
  logic [63:0]   valid;
  logic [EW-1:0] rdata;
  logic          rvalid;

  logic [3:0]  type_q;
  logic [11:0] addr_q;
  logic        wr_q;
  logic [7:0]  wval_q;
  logic [15:0] bank_q;
  logic [5:0]  kb_q;
  logic [2:0]  d_q;
  logic [21:0] nto_q;
  logic [31:0] mir_q;
  logic [22:0] size_q;
  logic [31:0] prod;
  logic [5:0]  count;
  logic [5:0]  y;
  logic [4:0]  s;
  logic [2:0]  j;

  logic        in_region;
  logic [3:0]  in_slot;
  logic [5:0]  raddr;
  logic [22:0] in_size;
  logic        accept;
  logic        out_load;

  logic                 div_start;
  logic                 div_done;
  logic [22:0]          div_rem;
  logic [32:0]          dividend;

  logic                   we;
  logic [5:0]             waddr;
  logic [3:0]             wtype;
  logic [OFFSET_BITS-1:0] woff;

  logic                   reg_q;
  logic [SUMW-1:0]        sum;
  logic [11:0]            low;

  assign in_item   = bst_pkg::in_item_t'(s_tdata[110:0]);
  assign in_region = in_item.mem_type[2];
  assign in_slot   = in_region ? in_item.addr[bst_pkg::CHR_PAGE_LOG2 +: 4]
                               : in_item.addr[bst_pkg::PRG_PAGE_LOG2 +: 4];
  assign raddr     = {in_region, in_item.mem_type[3], in_slot};
  assign in_size   = bst_pkg::mem_size(in_region, in_item.mem_type[1:0],
                                       prg_rom, prg_ram, chr_rom, chr_ram);

  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign out_load = (state == S_XLATE) || (state == S_FIN);
  assign m_tdata  = {4'b0, out_q};

  assign reg_q = type_q[2];

  // translate result from the registered table entry
  always_comb begin
    low = reg_q ? {2'b0, addr_q[9:0]} : addr_q[11:0];
    sum = SUMW'(rdata[OFFSET_BITS-1:0]) + SUMW'(low);
    xl  = '0;
    if (rvalid) begin
      xl.hit          = 1'b1;
      xl.region       = rdata[EW-2];
      xl.mem_select   = rdata[EW-3:EW-4];
      xl.phys_offset  = sum[22:0];
      xl.write_enable = wr_q && (rdata[EW-3:EW-4] != bst_pkg::MEM_ROM);
      xl.write_data   = xl.write_enable ? wval_q : 8'd0;
    end
  end

  assign dividend  = {1'b0, prod} + (reg_q ? {17'b0, y, 10'b0} : {15'b0, y, 12'b0});
  assign div_start = (state == S_LOOP) && !(y == count || s[4]);

  bst_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (size_q),
    .done     (div_done),
    .rem      (div_rem)
  );

  // table write port
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wtype = type_q;
    woff  = '0;
    unique case (state)
      S_WR: begin
        we    = 1'b1;
        waddr = {reg_q, type_q[3], s[3:0]};
        woff  = OFFSET_BITS'(div_rem);
      end
      S_NT1: begin
        we    = 1'b1;
        waddr = {reg_q, 2'b01, d_q};
        woff  = OFFSET_BITS'(nto_q);
      end
      S_NT2: begin
        we    = 1'b1;
        waddr = {reg_q, 3'b011, d_q[1:0]};
        woff  = OFFSET_BITS'(nto_q);
      end
      S_MIR: begin
        we    = 1'b1;
        waddr = {3'b101, j};
        wtype = bst_pkg::TYPE_CHR_CIRAM;
        woff  = OFFSET_BITS'({mir_q[3:0], 10'b0});
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wtype, woff};
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (accept && in_item.cmd == bst_pkg::CMD_UNMAP) begin
        valid[raddr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_rom <= '0;
      prg_ram <= '0;
      chr_rom <= '0;
      chr_ram <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bst_pkg::REG_PRG_ROM: prg_rom <= cfg_data;
        bst_pkg::REG_PRG_RAM: prg_ram <= cfg_data;
        bst_pkg::REG_CHR_ROM: chr_rom <= cfg_data;
        default:              chr_ram <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      rvalid <= valid[raddr];
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            type_q <= in_item.mem_type;
            addr_q <= in_item.addr[11:0];
            wr_q   <= in_item.is_write;
            wval_q <= in_item.write_value;
            bank_q <= in_item.bank;
            kb_q   <= in_item.bank_kb;
            d_q    <= in_item.nt_dest;
            nto_q  <= in_item.nt_offset;
            mir_q  <= in_item.mirror_word;
            size_q <= in_size;
            s      <= {1'b0, in_slot};
            y      <= '0;
            j      <= '0;
            unique case (in_item.cmd)
              bst_pkg::CMD_XLATE:  state <= S_XLATE;
              bst_pkg::CMD_MAP:    state <= (in_size != '0) ? S_MUL : S_FIN;
              bst_pkg::CMD_NT:     state <= (in_size != '0) ? S_NT1 : S_FIN;
              bst_pkg::CMD_MIRROR: state <= S_MIR;
              default:             state <= S_FIN;
            endcase
          end
        end
        S_XLATE: begin
          out_q    <= xl;
          m_tvalid <= 1'b1;
          state    <= S_IDLE;
        end
        S_MUL: begin
          prod  <= bank_q * {kb_q, 10'b0};
          count <= reg_q ? kb_q : {2'b0, kb_q[5:2]};
          state <= S_LOOP;
        end
        S_LOOP: begin
          state <= div_start ? S_DIV : S_FIN;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_WR;
          end
        end
        S_WR: begin
          y     <= y + 6'd1;
          s     <= s + 5'd1;
          state <= S_LOOP;
        end
        S_NT1: begin
          state <= d_q[2] ? S_FIN : S_NT2;
        end
        S_NT2: begin
          state <= S_FIN;
        end
        S_MIR: begin
          mir_q <= mir_q >> 4;
          j     <= j + 3'd1;
          if (j == 3'd7) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          out_q    <= '0;
          m_tvalid <= 1'b1;
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) s_tready |-> state == S_IDLE)
    else $error("input taken while busy");
  assert property (@(posedge clk) disable iff (rst) out_load |-> !m_tvalid || m_tready)
    else $error("result overwrites a stalled result");
  assert property (@(posedge clk) disable iff (rst) we |-> state != S_IDLE)
    else $error("table written while idle");
  assert property (@(posedge clk) disable iff (rst) div_done |-> state == S_DIV)
    else $error("remainder finished outside map walk");

endmodule
`default_nettype wire

// File: hdl/bst_rem.sv
// bit-serial remainder unit, one dividend bit per cycle
// uses bst_pkg widths
`default_nettype none
module bst_rem (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [bst_pkg::DIVD_W-1:0] dividend,
  input  wire logic [bst_pkg::SIZE_W-1:0] divisor,
  output logic                           done,
  output logic [bst_pkg::SIZE_W-1:0]     rem
);

  logic [bst_pkg::DIVD_W-1:0] dv;
  logic [5:0]                 cnt;
  logic                       busy;
  logic [bst_pkg::SIZE_W:0]   t;

  assign t = {rem, dv[bst_pkg::DIVD_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(bst_pkg::DIVD_W);
        dv   <= dividend;
        rem  <= '0;
      end else if (busy) begin
        dv <= dv << 1;
        if (t >= {1'b0, divisor}) begin
          rem <= bst_pkg::SIZE_W'(t - {1'b0, divisor});
        end else begin
          rem <= bst_pkg::SIZE_W'(t);
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("remainder done while busy");
  assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("remainder start not taken");
  assert property (@(posedge clk) disable iff (rst) busy |-> cnt != 6'd0)
    else $error("remainder count underflow");

endmodule
`default_nettype wire

// File: dv/testbench.sv
// testbench for bank_slot_translator: directed and random command streams
// checked against an in-bench slot table predictor; depends on bst_pkg
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [111:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [22:0] cfg_data = '0;

  bank_slot_translator u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam int OFF_W = 22;

  typedef struct {
    logic       valid;
    logic [3:0] kind;
    logic [OFF_W-1:0] offset;
  } slot_entry_t;

  typedef struct packed {
    logic [7:0]  write_data;
    logic        write_enable;
    logic [22:0] phys_offset;
    logic [1:0]  mem_select;
    logic        region;
    logic        hit;
  } access_t;

  slot_entry_t slots [64];
  logic [22:0] sizes [4];
  access_t pending_access [$];
  int errors = 0;
  int cycles = 0;
  bit quiet_in = 1'b0;
  bit quiet_out = 1'b0;

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic longint mem_bytes(logic rgn, logic [1:0] sel);
    if (!rgn) begin
      if (sel == bst_pkg::MEM_ROM) return longint'(sizes[bst_pkg::REG_PRG_ROM]);
      if (sel == bst_pkg::MEM_RAM) return longint'(sizes[bst_pkg::REG_PRG_RAM]);
      return 0;
    end
    case (sel)
      bst_pkg::MEM_ROM:  return longint'(sizes[bst_pkg::REG_CHR_ROM]);
      bst_pkg::MEM_RAM:  return longint'(sizes[bst_pkg::REG_CHR_RAM]);
      bst_pkg::MEM_XRAM: return 1024;
      default:           return 16384;
    endcase
  endfunction

  function automatic void put_slot(int idx, logic [3:0] kind, longint off);
    slots[idx].valid = 1'b1;
    slots[idx].kind = kind;
    slots[idx].offset = off[OFF_W-1:0];
  endfunction

  function automatic void place_nametable(int d, logic [3:0] kind, longint off);
    int base;
    base = kind[2] * 32;
    if (mem_bytes(kind[2], kind[1:0]) == 0) return;
    put_slot(base + 8 + d, kind, off);
    if (d < 4) put_slot(base + 12 + d, kind, off);
  endfunction

  function automatic access_t apply_command(bst_pkg::in_item_t it);
    access_t r;
    int shift, slot, idx;
    longint size, bytes, base, cnt;
    r = '0;
    shift = it.mem_type[2] ? 10 : 12;
    slot = (it.addr >> shift) & 15;
    idx = it.mem_type[2] * 32 + it.mem_type[3] * 16 + slot;
    case (it.cmd)
      bst_pkg::CMD_XLATE: if (slots[idx].valid) begin
        r.hit = 1'b1;
        r.region = slots[idx].kind[2];
        r.mem_select = slots[idx].kind[1:0];
        r.phys_offset = 23'(slots[idx].offset + (it.addr & ((1 << shift) - 1)));
        r.write_enable = it.is_write && slots[idx].kind[1:0] != bst_pkg::MEM_ROM;
        r.write_data = r.write_enable ? it.write_value : 8'd0;
      end
      bst_pkg::CMD_MAP: begin
        size = mem_bytes(it.mem_type[2], it.mem_type[1:0]);
        if (size != 0) begin
          bytes = longint'(it.bank_kb) * 1024;
          base = longint'(it.bank) * bytes;
          cnt = bytes >> shift;
          for (longint y = 0; y < cnt && slot + y < 16; y++)
            put_slot(idx + int'(y), it.mem_type, (base + (y << shift)) % size);
        end
      end
      bst_pkg::CMD_UNMAP: slots[idx] = '{1'b0, 4'd0, '0};
      bst_pkg::CMD_NT:
        place_nametable(int'(it.nt_dest), it.mem_type, longint'(it.nt_offset));
      bst_pkg::CMD_MIRROR:
        for (int j = 0; j < 8; j++)
          place_nametable(j, bst_pkg::TYPE_CHR_CIRAM,
                          longint'((it.mirror_word >> (j * 4)) & 32'hF) * 1024);
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(bst_pkg::in_item_t it);
    while (!quiet_in && $urandom_range(99) < 8) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, it.mirror_word, it.nt_offset, it.nt_dest, it.bank_kb, it.bank,
                it.write_value, it.is_write, it.addr, it.mem_type, it.cmd};
    do @(posedge clk); while (!s_tready);
    pending_access.push_back(apply_command(it));
  endtask

  always @(posedge clk) begin
    if (!rst) m_tready <= quiet_out || ($urandom_range(99) >= 8);
    if (!rst && m_tvalid && m_tready) begin
      access_t got, want;
      got = m_tdata[35:0];
      if (pending_access.size() == 0) begin
        $error("result with nothing expected: %h", m_tdata);
        errors++;
      end else begin
        want = pending_access.pop_front();
        if (got.hit != want.hit) begin
          $error("hit exp %0d got %0d", want.hit, got.hit);
          errors++;
        end
        if (got.region != want.region) begin
          $error("region exp %0d got %0d", want.region, got.region);
          errors++;
        end
        if (got.mem_select != want.mem_select) begin
          $error("mem_select exp %0d got %0d", want.mem_select, got.mem_select);
          errors++;
        end
        if (got.phys_offset != want.phys_offset) begin
          $error("phys_offset exp %h got %h", want.phys_offset, got.phys_offset);
          errors++;
        end
        if (got.write_enable != want.write_enable) begin
          $error("write_enable exp %0d got %0d", want.write_enable, got.write_enable);
          errors++;
        end
        if (got.write_data != want.write_data) begin
          $error("write_data exp %h got %h", want.write_data, got.write_data);
          errors++;
        end
      end
    end
  end

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_access.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_size(logic [1:0] idx, logic [22:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sizes[idx] = val;
    @(posedge clk);
  endtask

  function automatic bst_pkg::in_item_t rand_item();
    bst_pkg::in_item_t it;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[110:0];
    return it;
  endfunction

  function automatic bst_pkg::in_item_t xlate_at(logic [3:0] kind, logic [15:0] a, logic wr);
    bst_pkg::in_item_t it;
    it = rand_item();
    it.cmd = bst_pkg::CMD_XLATE;
    it.mem_type = kind;
    it.addr = a;
    it.is_write = wr;
    return it;
  endfunction

  task automatic test_directed();
    bst_pkg::in_item_t it;
    send_item(xlate_at(4'h0, 16'h0000, 1'b1));
    it = rand_item(); it.cmd = bst_pkg::CMD_MAP; it.mem_type = 4'h1; it.bank_kb = 6'd8;
    send_item(it);
    it = rand_item(); it.cmd = bst_pkg::CMD_MAP; it.mem_type = 4'h0; it.addr = 16'h8000;
    it.bank = 16'hFFFF; it.bank_kb = 6'd32; send_item(it);
    it = rand_item(); it.cmd = bst_pkg::CMD_MAP; it.mem_type = 4'h0; it.addr = 16'hF000;
    it.bank = 16'd0; it.bank_kb = 6'd32; send_item(it);
    it = rand_item(); it.cmd = bst_pkg::CMD_MAP; it.mem_type = 4'h4; it.bank_kb = 6'd0;
    send_item(it);
    it = rand_item(); it.cmd = bst_pkg::CMD_MAP; it.mem_type = 4'hC; it.addr = 16'hFC00;
    it.bank_kb = 6'd1; it.bank = 16'h1234; send_item(it);
    it = rand_item(); it.cmd = bst_pkg::CMD_MAP; it.mem_type = 4'h0; it.bank_kb = 6'd2;
    send_item(it);
    for (int a = 0; a < 16; a += 5) send_item(xlate_at(4'h0, 16'(a << 12) | 16'hFFF, 1'b1));
    send_item(xlate_at(4'hC, 16'hFFFF, 1'b1));
    it = rand_item(); it.cmd = bst_pkg::CMD_NT; it.mem_type = 4'h6; it.nt_dest = 3'd0;
    it.nt_offset = 22'h3FFFFF; send_item(it);
    it = rand_item(); it.cmd = bst_pkg::CMD_NT; it.mem_type = 4'h2; it.nt_dest = 3'd7;
    send_item(it);
    it = rand_item(); it.cmd = bst_pkg::CMD_MIRROR; it.mirror_word = 32'hFEDC_BA98;
    send_item(it);
    send_item(xlate_at(4'h4, 16'h2000, 1'b1));
    send_item(xlate_at(4'h4, 16'h3FFF, 1'b0));
    it = rand_item(); it.cmd = bst_pkg::CMD_UNMAP; it.mem_type = 4'h4; it.addr = 16'h2000;
    send_item(it);
    send_item(xlate_at(4'h4, 16'h2000, 1'b1));
    for (int c = 5; c < 8; c++) begin
      it = rand_item(); it.cmd = 3'(c); send_item(it);
    end
    drain();
  endtask

  task automatic test_random(int n);
    bst_pkg::in_item_t it;
    for (int i = 0; i < n; i++) begin
      quiet_in = (i % 200) >= 150;
      quiet_out = quiet_in;
      it = rand_item();
      it.mem_type[1:0] = ($urandom_range(3) == 0) ? bst_pkg::MEM_RAM : it.mem_type[1:0];
      case ($urandom_range(19))
        0, 1, 2: begin
          it.cmd = bst_pkg::CMD_MAP;
          it.bank_kb = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) :
                       6'(1 << $urandom_range(5));
          if ($urandom_range(1)) it.bank = 16'($urandom_range(31));
        end
        3: it.cmd = bst_pkg::CMD_UNMAP;
        4: it.cmd = bst_pkg::CMD_NT;
        5: it.cmd = ($urandom_range(3) == 0) ? 3'($urandom_range(5, 7)) : bst_pkg::CMD_MIRROR;
        default: it.cmd = bst_pkg::CMD_XLATE;
      endcase
      send_item(it);
    end
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    drain();
  endtask

  initial begin
    foreach (slots[i]) slots[i] = '{1'b0, 4'd0, '0};
    foreach (sizes[i]) sizes[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_size(bst_pkg::REG_PRG_RAM, 23'd8192);
    write_size(bst_pkg::REG_PRG_ROM, 23'h400000);
    test_directed();
    write_size(bst_pkg::REG_CHR_ROM, 23'd24576);
    write_size(bst_pkg::REG_CHR_RAM, 23'h7FFFFF);
    write_size(bst_pkg::REG_PRG_ROM, 23'd40960);
    test_random(170);
    write_size(bst_pkg::REG_PRG_ROM, 23'd3);
    write_size(bst_pkg::REG_PRG_RAM, 23'h7FFFFF);
    write_size(bst_pkg::REG_CHR_ROM, 23'd0);
    write_size(bst_pkg::REG_CHR_RAM, 23'd1);
    test_random(160);
    write_size(bst_pkg::REG_PRG_ROM, 23'($urandom_range(1, 23'h7FFFFF)));
    write_size(bst_pkg::REG_PRG_RAM, 23'd0);
    write_size(bst_pkg::REG_CHR_ROM, 23'h400000);
    write_size(bst_pkg::REG_CHR_RAM, 23'd8192);
    test_random(170);
    if (errors == 0 && pending_access.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
